>>> hw/rtl/assert_macros.svh
// assertion macros used by the rtl datapath
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_NOW(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> hw/rtl/lss_pkg.sv
// types, constants and control structs of the search stack
`default_nettype none

package lss_pkg;

  localparam int DEPTH        = 64;
  localparam int ELEM_WIDTH   = 32;
  localparam int ADDR_W       = $clog2(DEPTH);
  localparam int CNT_W        = $clog2(DEPTH + 1);
  localparam int CMD_W        = 3;
  localparam int IN_DATA_W    = 32;
  localparam int DATA_W       = 32;
  localparam int COUNT_W      = 7;
  localparam int STATUS_W     = 2;
  localparam int OUT_FIELDS_W = DATA_W + 1 + COUNT_W + 1 + STATUS_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH     = 3'd0,
    CMD_POP      = 3'd1,
    CMD_PEEK     = 3'd2,
    CMD_CONTAINS = 3'd3,
    CMD_CLEAR    = 3'd4
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_UNDERFLOW = 2'd1,
    STAT_OVERFLOW  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CNT_HOLD = 2'd0,
    CNT_INC  = 2'd1,
    CNT_DEC  = 2'd2,
    CNT_CLR  = 2'd3
  } cnt_op_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_READ = 2'd2,
    S_SCAN = 2'd3
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic    in_load;
    logic    mem_wr;
    logic    rd_top;
    logic    scan_start;
    logic    scan_run;
    cnt_op_e cnt_op;
    logic    out_load;
    status_e out_status;
    logic    out_data;
    logic    out_found;
  } lss_cmd_t;

  // datapath to controller
  typedef struct packed {
    cmd_e cmd;
    logic full;
    logic empty;
    logic scan_done;
    logic out_free;
  } lss_stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/lifo_stack_with_search.sv
// top level of the bounded stack with search
//
//   channel  dir  tdata fields (lsb first)                     tuser
//   s_axis   in   element[31:0]                                command[2:0]
//   m_axis   out  data_out[31:0] found count[6:0] is_empty     -
//                 status[1:0], zero pad to 48 bits
//
// push, clear, unused and underflow answer from exec, pop/peek from read (one memory read)
// contains reads one held entry per cycle on the single read port until a hit or the end
// reset zeroes the count, search state and output valid, storage is not cleared
// a finished result waits in the output register while the next transaction is
// accepted and worked; that one holds before its result load until the register frees
`default_nettype none

module lifo_stack_with_search (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [lss_pkg::IN_DATA_W-1:0]  s_axis_tdata,   // element
  input  logic [lss_pkg::CMD_W-1:0]      s_axis_tuser,   // command
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [lss_pkg::OUT_DATA_W-1:0] m_axis_tdata    // data_out, found, count, is_empty, status
);
  import lss_pkg::*;

  lss_cmd_t  ctrl_cmd;
  lss_stat_t dp_stat;

  lss_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .stat_i    (dp_stat),
    .cmd_o     (ctrl_cmd)
  );

  lss_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tdata_i  (s_axis_tdata),
    .s_tuser_i  (s_axis_tuser),
    .cmd_i      (ctrl_cmd),
    .stat_o     (dp_stat),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_o  (m_axis_tdata)
  );

endmodule

`default_nettype wire

>>> hw/rtl/lss_ctrl.sv
// sequencing state machine of the search stack
`default_nettype none

module lss_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  output logic              s_ready_o,
  input  lss_pkg::lss_stat_t stat_i,
  output lss_pkg::lss_cmd_t  cmd_o
);
  import lss_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (s_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        unique case (stat_i.cmd) inside
          CMD_POP, CMD_PEEK: begin
            if (!stat_i.empty) state_d = S_READ;
            else if (stat_i.out_free) state_d = S_IDLE;
          end
          CMD_CONTAINS: begin
            if (!stat_i.empty) state_d = S_SCAN;
            else if (stat_i.out_free) state_d = S_IDLE;
          end
          default: begin
            if (stat_i.out_free) state_d = S_IDLE;
          end
        endcase
      end
      S_READ: begin
        if (stat_i.out_free) state_d = S_IDLE;
      end
      S_SCAN: begin
        if (stat_i.scan_done && stat_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o     = '0;
    s_ready_o = (state_q == S_IDLE);
    unique case (state_q)
      S_IDLE: begin
        cmd_o.in_load = s_valid_i;
      end
      S_EXEC: begin
        unique case (stat_i.cmd) inside
          CMD_PUSH: begin
            if (stat_i.out_free) begin
              cmd_o.out_load = 1'b1;
              if (stat_i.full) begin
                cmd_o.out_status = STAT_OVERFLOW;
              end else begin
                cmd_o.mem_wr = 1'b1;
                cmd_o.cnt_op = CNT_INC;
              end
            end
          end
          CMD_POP, CMD_PEEK: begin
            if (!stat_i.empty) begin
              cmd_o.rd_top = 1'b1;
            end else if (stat_i.out_free) begin
              cmd_o.out_load   = 1'b1;
              cmd_o.out_status = STAT_UNDERFLOW;
            end
          end
          CMD_CONTAINS: begin
            if (!stat_i.empty) begin
              cmd_o.scan_start = 1'b1;
            end else if (stat_i.out_free) begin
              cmd_o.out_load = 1'b1;
            end
          end
          CMD_CLEAR: begin
            if (stat_i.out_free) begin
              cmd_o.out_load = 1'b1;
              cmd_o.cnt_op   = CNT_CLR;
            end
          end
          default: begin
            // unused codes answer with the current state only
            if (stat_i.out_free) cmd_o.out_load = 1'b1;
          end
        endcase
      end
      S_READ: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_data = 1'b1;
          cmd_o.cnt_op   = (stat_i.cmd == CMD_POP) ? CNT_DEC : CNT_HOLD;
        end
      end
      S_SCAN: begin
        cmd_o.scan_run = 1'b1;
        if (stat_i.scan_done && stat_i.out_free) begin
          cmd_o.out_load  = 1'b1;
          cmd_o.out_found = 1'b1;
        end
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

`default_nettype wire

>>> hw/rtl/lss_dpath.sv
// storage, count, search pointer and result register of the search stack
`default_nettype none
`include "assert_macros.svh"

module lss_dpath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [lss_pkg::IN_DATA_W-1:0]  s_tdata_i,
  input  logic [lss_pkg::CMD_W-1:0]      s_tuser_i,
  input  lss_pkg::lss_cmd_t              cmd_i,
  output lss_pkg::lss_stat_t             stat_o,
  output logic                           m_tvalid_o,
  input  logic                           m_tready_i,
  output logic [lss_pkg::OUT_DATA_W-1:0] m_tdata_o
);
  import lss_pkg::*;

  logic [ELEM_WIDTH-1:0] mem [DEPTH];
  logic [ELEM_WIDTH-1:0] rdata_q;
  logic [ELEM_WIDTH-1:0] elem_q;
  cmd_e                  cmd_q;

  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [CNT_W-1:0]      ptr_q;
  logic                  cmp_vld_q;
  logic                  hit_q;

  logic                  full;
  logic                  empty;
  logic                  issue;
  logic                  rd_en;
  logic [ADDR_W-1:0]     rd_addr;
  logic                  out_free;

  logic                  out_vld_q;
  logic [DATA_W-1:0]     out_data_q;
  logic                  out_found_q;
  logic [COUNT_W-1:0]    out_count_q;
  logic                  out_empty_q;
  status_e               out_status_q;

  assign full     = (cnt_q == CNT_W'(DEPTH));
  assign empty    = (cnt_q == '0);
  assign out_free = !out_vld_q || m_tready_i;

  // one entry read per cycle while the search runs, until a hit or the last held entry
  assign issue   = cmd_i.scan_run && !hit_q && (ptr_q < cnt_q);
  assign rd_en   = cmd_i.rd_top || issue;
  assign rd_addr = cmd_i.rd_top ? ADDR_W'(cnt_q - CNT_W'(1)) : ptr_q[ADDR_W-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      cmd_q  <= cmd_e'(s_tuser_i);
      elem_q <= ELEM_WIDTH'(s_tdata_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_wr) mem[cnt_q[ADDR_W-1:0]] <= elem_q;
    if (rd_en) rdata_q <= mem[rd_addr];
  end

  always_comb begin
    case (cmd_i.cnt_op)
      CNT_INC: cnt_d = cnt_q + CNT_W'(1);
      CNT_DEC: cnt_d = cnt_q - CNT_W'(1);
      CNT_CLR: cnt_d = '0;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      ptr_q     <= '0;
      cmp_vld_q <= 1'b0;
      hit_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (cmd_i.scan_start) begin
        ptr_q     <= '0;
        cmp_vld_q <= 1'b0;
        hit_q     <= 1'b0;
      end else if (cmd_i.scan_run) begin
        if (issue) ptr_q <= ptr_q + CNT_W'(1);
        cmp_vld_q <= issue;
        if (cmp_vld_q && (rdata_q == elem_q)) hit_q <= 1'b1;
      end
      if (cmd_i.out_load) out_vld_q <= 1'b1;
      else if (m_tready_i) out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_q   <= cmd_i.out_data ? DATA_W'(rdata_q) : '0;
      out_found_q  <= cmd_i.out_found && hit_q;
      out_count_q  <= COUNT_W'(cnt_d);
      out_empty_q  <= (cnt_d == '0);
      out_status_q <= cmd_i.out_status;
    end
  end

  assign stat_o.cmd       = cmd_q;
  assign stat_o.full      = full;
  assign stat_o.empty     = empty;
  assign stat_o.scan_done = hit_q || ((ptr_q >= cnt_q) && !cmp_vld_q);
  assign stat_o.out_free  = out_free;

  assign m_tvalid_o = out_vld_q;
  assign m_tdata_o  = OUT_DATA_W'({out_status_q, out_empty_q, out_count_q,
                                   out_found_q, out_data_q});

  `ASSERT_NOW(a_wr_not_full, cmd_i.mem_wr, !full, "push write into a full stack")
  `ASSERT_NOW(a_rd_not_empty, cmd_i.rd_top, !empty, "top read from an empty stack")
  `ASSERT_NOW(a_load_free, cmd_i.out_load, out_free, "pending result overwritten")
  `ASSERT_NEXT(a_pop_dec, cmd_i.cnt_op == CNT_DEC, cnt_q == $past(cnt_q) - CNT_W'(1), "no decrement")

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
// self-checking testbench of the search stack: directed table, then random transactions
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lss_pkg::*;

  localparam int ITEM_TARGET    = 1650;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = DEPTH + 16;

  // command codes the block treats as no operation
  localparam logic [CMD_W-1:0] CMD_UNUSED_LO  = 3'd5;
  localparam logic [CMD_W-1:0] CMD_UNUSED_MID = 3'd6;
  localparam logic [CMD_W-1:0] CMD_UNUSED_HI  = 3'd7;

  typedef struct packed {
    logic [DATA_W-1:0]  data_out;
    logic               found;
    logic [COUNT_W-1:0] count;
    logic               is_empty;
    status_e            status;
  } stack_result_t;

  typedef struct {
    logic [CMD_W-1:0]     cmd;
    logic [IN_DATA_W-1:0] elem;
    int                   reps;
    bit                   typed;
    stack_result_t        res;
  } stim_row_t;

  typedef enum logic [1:0] {
    RDY_ALWAYS   = 2'd0,
    RDY_COIN     = 2'd1,
    RDY_SPARSE   = 2'd2,
    RDY_PERIODIC = 2'd3
  } rdy_mode_e;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;   // element
  logic [CMD_W-1:0]      s_axis_tuser  = '0;   // command
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;         // data_out, found, count, is_empty, status

  // predictor state
  logic [ELEM_WIDTH-1:0] stack_mem [DEPTH];
  int                    stack_cnt = 0;

  stack_result_t awaited_results [$];
  stim_row_t     stim_rows [$];
  int            err_count  = 0;
  int            n_issued   = 0;
  int            burst_left = 0;
  rdy_mode_e     rdy_mode   = RDY_ALWAYS;
  int            rdy_left   = 0;

  always #2 clk_i = ~clk_i;

  lifo_stack_with_search u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  function automatic stack_result_t next_stack_result(logic [CMD_W-1:0] cmd,
                                                      logic [IN_DATA_W-1:0] elem);
    stack_result_t r;
    r        = '0;
    r.status = STAT_OK;
    case (cmd)
      CMD_PUSH: begin
        if (stack_cnt >= DEPTH) begin
          r.status = STAT_OVERFLOW;
        end else begin
          stack_mem[stack_cnt] = elem[ELEM_WIDTH-1:0];
          stack_cnt++;
        end
      end
      CMD_POP, CMD_PEEK: begin
        if (stack_cnt == 0) begin
          r.status = STAT_UNDERFLOW;
        end else begin
          r.data_out = DATA_W'(stack_mem[stack_cnt-1]);
          if (cmd == CMD_POP) stack_cnt--;
        end
      end
      CMD_CONTAINS: begin
        for (int i = 0; i < stack_cnt; i++)
          if (stack_mem[i] == elem[ELEM_WIDTH-1:0]) r.found = 1'b1;
      end
      CMD_CLEAR: begin
        stack_cnt = 0;
      end
      default: begin
      end
    endcase
    r.count    = COUNT_W'(stack_cnt);
    r.is_empty = (stack_cnt == 0);
    return r;
  endfunction

  function automatic stack_result_t exp_res(logic [DATA_W-1:0] data, logic found,
                                            int count, status_e status);
    stack_result_t r;
    r.data_out = data;
    r.found    = found;
    r.count    = COUNT_W'(count);
    r.is_empty = (count == 0);
    r.status   = status;
    return r;
  endfunction

  function automatic void add_row(logic [CMD_W-1:0] cmd, logic [IN_DATA_W-1:0] elem,
                                  int reps, bit typed, stack_result_t res);
    stim_row_t row;
    row.cmd   = cmd;
    row.elem  = elem;
    row.reps  = reps;
    row.typed = typed;
    row.res   = res;
    stim_rows.push_back(row);
  endfunction

  // element source: mostly random, some corner values, some values already held
  function automatic logic [IN_DATA_W-1:0] pick_elem();
    int sel;
    sel = $urandom_range(0, 5);
    if (sel == 3) begin
      case ($urandom_range(0, 3))
        0:       return 32'h0000_0000;
        1:       return 32'hffff_ffff;
        2:       return 32'h8000_0000;
        default: return 32'h0000_0001;
      endcase
    end
    if (sel >= 4 && stack_cnt > 0)
      return IN_DATA_W'(stack_mem[$urandom_range(0, stack_cnt - 1)]);
    return $urandom;
  endfunction

  function automatic logic [CMD_W-1:0] pick_cmd();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return CMD_PUSH;
    if (r < 60) return CMD_POP;
    if (r < 70) return CMD_PEEK;
    if (r < 92) return CMD_CONTAINS;
    if (r < 96) return CMD_CLEAR;
    return CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
  endfunction

  // sends one transaction in bursts with random gaps, then logs what it should return
  task automatic issue_cmd(input logic [CMD_W-1:0] cmd, input logic [IN_DATA_W-1:0] elem,
                           input bit typed, input stack_result_t typed_res);
    int            gap;
    stack_result_t predicted;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 40);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= elem;
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = next_stack_result(cmd, elem);
    awaited_results.push_back(typed ? typed_res : predicted);
    n_issued++;
  endtask

  task automatic cmp_field(input string name, input logic [DATA_W-1:0] want,
                           input logic [DATA_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
      err_count++;
    end
  endtask

  // receiver stall pattern
  always @(posedge clk_i) begin
    if (rdy_left == 0) begin
      rdy_mode <= rdy_mode_e'($urandom_range(0, 3));
      rdy_left <= $urandom_range(8, 64);
    end else begin
      rdy_left <= rdy_left - 1;
    end
    case (rdy_mode)
      RDY_ALWAYS:   m_axis_tready <= 1'b1;
      RDY_COIN:     m_axis_tready <= 1'($urandom_range(0, 1));
      RDY_SPARSE:   m_axis_tready <= ($urandom_range(0, 3) == 0);
      default:      m_axis_tready <= (rdy_left[3:0] == 4'd0);
    endcase
  end

  always @(posedge clk_i) begin : result_mon
    stack_result_t got;
    stack_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.data_out = m_axis_tdata[31:0];
      got.found    = m_axis_tdata[32];
      got.count    = m_axis_tdata[39:33];
      got.is_empty = m_axis_tdata[40];
      got.status   = status_e'(m_axis_tdata[42:41]);
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected transaction, expected none actual %h", $time,
                 m_axis_tdata);
        err_count++;
      end else begin
        want = awaited_results.pop_front();
        cmp_field("data_out", want.data_out, got.data_out);
        cmp_field("found", DATA_W'(want.found), DATA_W'(got.found));
        cmp_field("count", DATA_W'(want.count), DATA_W'(got.count));
        cmp_field("is_empty", DATA_W'(want.is_empty), DATA_W'(got.is_empty));
        cmp_field("status", DATA_W'(want.status), DATA_W'(got.status));
      end
    end
  end

  // watchdog: ends the run when no transaction moves for too long
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    int seg;
    int n;

    // empty stack after reset
    add_row(CMD_POP,        32'h0000_0000, 1, 1, exp_res('0, 1'b0, 0, STAT_UNDERFLOW));
    add_row(CMD_PEEK,       32'hffff_ffff, 1, 1, exp_res('0, 1'b0, 0, STAT_UNDERFLOW));
    add_row(CMD_CONTAINS,   32'hffff_ffff, 1, 1, exp_res('0, 1'b0, 0, STAT_OK));
    add_row(CMD_UNUSED_LO,  32'h0000_0000, 1, 1, exp_res('0, 1'b0, 0, STAT_OK));
    add_row(CMD_UNUSED_HI,  32'hffff_ffff, 1, 1, exp_res('0, 1'b0, 0, STAT_OK));
    // element extremes
    add_row(CMD_PUSH,       32'hffff_ffff, 1, 1, exp_res('0, 1'b0, 1, STAT_OK));
    add_row(CMD_PEEK,       32'h0000_0000, 1, 1, exp_res('1, 1'b0, 1, STAT_OK));
    add_row(CMD_PUSH,       32'h0000_0000, 1, 1, exp_res('0, 1'b0, 2, STAT_OK));
    add_row(CMD_CONTAINS,   32'hffff_ffff, 1, 1, exp_res('0, 1'b1, 2, STAT_OK));
    add_row(CMD_CONTAINS,   32'h0000_0000, 1, 1, exp_res('0, 1'b1, 2, STAT_OK));
    add_row(CMD_CONTAINS,   32'h8000_0000, 1, 1, exp_res('0, 1'b0, 2, STAT_OK));
    add_row(CMD_UNUSED_MID, 32'h8000_0000, 1, 1, exp_res('0, 1'b0, 2, STAT_OK));
    add_row(CMD_POP,        32'h0000_0000, 1, 1, exp_res('0, 1'b0, 1, STAT_OK));
    add_row(CMD_POP,        32'h0000_0000, 1, 1, exp_res('1, 1'b0, 0, STAT_OK));
    add_row(CMD_CLEAR,      32'h0000_0000, 1, 1, exp_res('0, 1'b0, 0, STAT_OK));
    // clear leaves stale storage that must stay invisible
    add_row(CMD_PUSH,       32'h1234_5678, 1, 0, '0);
    add_row(CMD_CLEAR,      32'hffff_ffff, 1, 1, exp_res('0, 1'b0, 0, STAT_OK));
    add_row(CMD_POP,        32'h0000_0000, 1, 1, exp_res('0, 1'b0, 0, STAT_UNDERFLOW));
    add_row(CMD_CONTAINS,   32'h1234_5678, 1, 1, exp_res('0, 1'b0, 0, STAT_OK));
    // fill to the top, then push into a full stack
    add_row(CMD_PUSH,       32'h0000_0001, DEPTH, 0, '0);
    add_row(CMD_PUSH,       32'hffff_ffff, 1, 1, exp_res('0, 1'b0, DEPTH, STAT_OVERFLOW));
    add_row(CMD_CONTAINS,   32'h0000_0001, 1, 1, exp_res('0, 1'b1, DEPTH, STAT_OK));
    add_row(CMD_CONTAINS,   DEPTH,         1, 1, exp_res('0, 1'b1, DEPTH, STAT_OK));
    add_row(CMD_PEEK,       32'h0000_0000, 1, 0, '0);
    add_row(CMD_POP,        32'h0000_0000, 1, 0, '0);
    add_row(CMD_CLEAR,      32'h0000_0000, 1, 1, exp_res('0, 1'b0, 0, STAT_OK));

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stim_rows[i])
      for (int k = 0; k < stim_rows[i].reps; k++)
        issue_cmd(stim_rows[i].cmd, stim_rows[i].elem + k, stim_rows[i].typed,
                  stim_rows[i].res);

    // random segments: fill to overflow, drain with pops and peeks past the count, or a mixed run
    while (n_issued < ITEM_TARGET) begin
      seg = $urandom_range(0, 9);
      if (seg == 0) begin
        n = DEPTH - stack_cnt + $urandom_range(1, 3);
        repeat (n) issue_cmd(CMD_PUSH, pick_elem(), 1'b0, '0);
      end else if (seg == 1) begin
        n = stack_cnt + $urandom_range(1, 2);
        repeat (n)
          issue_cmd(($urandom_range(0, 4) == 0) ? CMD_PEEK : CMD_POP, pick_elem(), 1'b0, '0);
      end else begin
        n = $urandom_range(10, 60);
        repeat (n) issue_cmd(pick_cmd(), pick_elem(), 1'b0, '0);
      end
    end

    s_axis_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
